>>> rtl/core/mfcl_pkg.sv
// shared types, codes and reset values for the motor fault confirm latch
package mfcl_pkg;

   // fault codes as reported on fault_code
   typedef enum logic [2:0] {
      FAULT_NONE        = 3'd0,
      FAULT_OVERCURRENT = 3'd1,
      FAULT_OVERTEMP    = 3'd2,
      FAULT_UNDERVOLT   = 3'd3,
      FAULT_STALL       = 3'd4
   } fault_type;

   // operation codes of an input transaction
   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_CURRENT_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BUS_MIN       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OC_HOLD       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OT_HOLD       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STALL_HOLD    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RECOVER_WAIT  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RETRY_LIMIT   = 3'd7;

   // stall speed window, |rpm| below this
   localparam logic signed [15:0] STALL_RPM = 16'sd30;
   localparam logic [7:0] RETRY_MAX = 8'd255;

   typedef struct packed {
      logic [14:0]        current_limit_ma;
      logic signed [15:0] temp_limit_tenths;
      logic [15:0]        bus_min_mv;
      logic [31:0]        overcurrent_hold_ms;
      logic [31:0]        overtemp_hold_ms;
      logic [31:0]        stall_hold_ms;
      logic [31:0]        recover_wait_ms;
      logic [7:0]         retry_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      current_limit_ma:    15'd8000,
      temp_limit_tenths:   16'sd800,
      bus_min_mv:          16'd10000,
      overcurrent_hold_ms: 32'd100,
      overtemp_hold_ms:    32'd1000,
      stall_hold_ms:       32'd2000,
      recover_wait_ms:     32'd5000,
      retry_limit:         8'd3
   };

   typedef struct packed {
      logic               operation;
      logic [31:0]        now_ms;
      logic signed [15:0] duty;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] motor_current;
      logic [15:0]        bus_mv;
      logic signed [15:0] temp_tenths;
      logic               running;
   } item_type;

   // candidate from one sample and the hold time it must persist
   typedef struct packed {
      fault_type   cand;
      logic [31:0] hold;
   } det_type;

   typedef struct packed {
      fault_type   fault_code;
      logic        emergency_stop;
      logic        recover_allowed;
      logic [31:0] latch_count;
      logic [7:0]  retry_total;
   } result_type;

endpackage

>>> rtl/core/mfcl_if.sv
// valid/ready channel interfaces for sample and result transactions
interface mfcl_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [31:0]        now_ms;
   logic signed [15:0] duty;
   logic signed [15:0] speed_rpm;
   logic signed [15:0] motor_current;
   logic [15:0]        bus_mv;
   logic signed [15:0] temp_tenths;
   logic               running;

   modport source (output valid, output operation, output now_ms, output duty,
                   output speed_rpm, output motor_current, output bus_mv,
                   output temp_tenths, output running, input ready);
   modport sink (input valid, input operation, input now_ms, input duty,
                 input speed_rpm, input motor_current, input bus_mv,
                 input temp_tenths, input running, output ready);
endinterface

interface mfcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  fault_code;
   logic        emergency_stop;
   logic        recover_allowed;
   logic [31:0] latch_count;
   logic [7:0]  retry_total;

   modport source (output valid, output fault_code, output emergency_stop,
                   output recover_allowed, output latch_count, output retry_total,
                   input ready);
   modport sink (input valid, input fault_code, input emergency_stop,
                 input recover_allowed, input latch_count, input retry_total,
                 output ready);
endinterface

>>> rtl/core/mfcl_detect.sv
// fault candidate classification of one motor sample
module mfcl_detect
   import mfcl_pkg::*;
(
   input  item_type item,
   input  cfg_type  cfg,
   output det_type  det
);

   logic over_current;
   logic over_temp;
   logic under_volt;
   logic stalled;

   assign over_current = item.motor_current > $signed({1'b0, cfg.current_limit_ma});
   assign over_temp    = item.temp_tenths > cfg.temp_limit_tenths;
   assign under_volt   = item.running && (item.bus_mv < cfg.bus_min_mv);
   // |rpm| < 30 written as a signed window, no negation needed
   assign stalled      = item.running && (item.duty > 16'sd0) &&
                         (item.speed_rpm < STALL_RPM) && (item.speed_rpm > -STALL_RPM);

   // earlier tests win, stall on top
   always_comb begin
      det.cand = FAULT_NONE;
      det.hold = '0;
      if (stalled) begin
         det.cand = FAULT_STALL;
         det.hold = cfg.stall_hold_ms;
      end else if (under_volt) begin
         det.cand = FAULT_UNDERVOLT;
         det.hold = '0;
      end else if (over_temp) begin
         det.cand = FAULT_OVERTEMP;
         det.hold = cfg.overtemp_hold_ms;
      end else if (over_current) begin
         det.cand = FAULT_OVERCURRENT;
         det.hold = cfg.overcurrent_hold_ms;
      end
   end

endmodule

>>> rtl/core/mfcl_latch.sv
// confirmation timer, fault latch, counters and result formation
module mfcl_latch
   import mfcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  item_type    item,
   input  det_type     det,
   input  cfg_type     cfg,
   output result_type  result
);

   fault_type   latched_fault_ff, latched_fault_in;
   logic [31:0] latch_time_ff, latch_time_in;
   logic [7:0]  retries_ff, retries_in;
   logic [31:0] faults_seen_ff, faults_seen_in;
   fault_type   pending_fault_ff, pending_fault_in;
   logic [31:0] pending_since_ff, pending_since_in;

   logic        pend_match;
   logic [31:0] pend_elapsed;
   logic        confirmed;
   logic        do_latch;
   logic [31:0] cool_elapsed;

   assign pend_match   = (pending_fault_ff == det.cand);
   assign pend_elapsed = item.now_ms - pending_since_ff;
   // a changed candidate restarts at zero, so only a zero hold latches then
   assign confirmed    = (det.hold == 32'd0) || (pend_match && (pend_elapsed >= det.hold));

   always_comb begin
      latched_fault_in = latched_fault_ff;
      latch_time_in    = latch_time_ff;
      retries_in       = retries_ff;
      faults_seen_in   = faults_seen_ff;
      pending_fault_in = pending_fault_ff;
      pending_since_in = pending_since_ff;
      do_latch         = 1'b0;
      if (item.operation == OP_CLEAR) begin
         latched_fault_in = FAULT_NONE;
         latch_time_in    = '0;
         if (retries_ff != RETRY_MAX) begin
            retries_in = retries_ff + 8'd1;
         end
      end else if (latched_fault_ff == FAULT_NONE) begin
         if (det.cand == FAULT_NONE) begin
            pending_fault_in = FAULT_NONE;
         end else if (confirmed) begin
            do_latch         = 1'b1;
            latched_fault_in = det.cand;
            latch_time_in    = item.now_ms;
            pending_fault_in = FAULT_NONE;
            faults_seen_in   = faults_seen_ff + 32'd1;
         end else if (!pend_match) begin
            pending_fault_in = det.cand;
            pending_since_in = item.now_ms;
         end
      end
   end

   assign cool_elapsed = item.now_ms - latch_time_in;

   always_comb begin
      result.fault_code      = latched_fault_in;
      result.emergency_stop  = do_latch;
      result.recover_allowed = (latched_fault_in != FAULT_NONE) &&
                               (cool_elapsed >= cfg.recover_wait_ms) &&
                               (retries_in < cfg.retry_limit);
      result.latch_count     = faults_seen_in;
      result.retry_total     = retries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_fault_ff <= FAULT_NONE;
         latch_time_ff    <= '0;
         retries_ff       <= '0;
         faults_seen_ff   <= '0;
         pending_fault_ff <= FAULT_NONE;
         pending_since_ff <= '0;
      end else if (fire) begin
         latched_fault_ff <= latched_fault_in;
         latch_time_ff    <= latch_time_in;
         retries_ff       <= retries_in;
         faults_seen_ff   <= faults_seen_in;
         pending_fault_ff <= pending_fault_in;
         pending_since_ff <= pending_since_in;
      end
   end

endmodule

>>> rtl/core/motor_fault_confirm_latch_core.sv
// top level of the motor fault confirm latch: registers, handshakes, checks
//
//   channel   dir  handshake          payload
//   req_ch    in   valid/ready        operation, now_ms, duty, speed_rpm,
//                                     motor_current, bus_mv, temp_tenths, running
//   rsp_ch    out  valid/ready        fault_code, emergency_stop,
//                                     recover_allowed, latch_count, retry_total
//   csr_*     in   csr_we only        csr_index, csr_wdata
//
// one transaction per cycle sustained unless rsp stalls; a request reaches rsp
// via the input and result registers; the fault state loop sets the rate
// sync active-high reset clears valid and fault state, loads register defaults
// a stalled rsp holds its result; the input register still fills behind it
module motor_fault_confirm_latch_core
   import mfcl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   mfcl_req_if.sink               req_ch,
   mfcl_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // input register stage
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;

   // result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       advance;
   logic       stage_fire;
   det_type    det;
   result_type result;

   // ---------------------------------------------------------------------
   // configuration writes, each field truncated to its register width
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CURRENT_LIMIT: cfg_in.current_limit_ma    = csr_wdata[14:0];
            REG_TEMP_LIMIT:    cfg_in.temp_limit_tenths   = $signed(csr_wdata[15:0]);
            REG_BUS_MIN:       cfg_in.bus_min_mv          = csr_wdata[15:0];
            REG_OC_HOLD:       cfg_in.overcurrent_hold_ms = csr_wdata;
            REG_OT_HOLD:       cfg_in.overtemp_hold_ms    = csr_wdata;
            REG_STALL_HOLD:    cfg_in.stall_hold_ms       = csr_wdata;
            REG_RECOVER_WAIT:  cfg_in.recover_wait_ms     = csr_wdata;
            REG_RETRY_LIMIT:   cfg_in.retry_limit         = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake: the result register frees when empty or taken this cycle,
   // and the input register moves into it whenever it frees
   // ---------------------------------------------------------------------
   assign advance    = !rsp_valid_ff || rsp_ch.ready;
   assign stage_fire = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire   = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_item_in.operation     = req_ch.operation;
      s1_item_in.now_ms        = req_ch.now_ms;
      s1_item_in.duty          = req_ch.duty;
      s1_item_in.speed_rpm     = req_ch.speed_rpm;
      s1_item_in.motor_current = req_ch.motor_current;
      s1_item_in.bus_mv        = req_ch.bus_mv;
      s1_item_in.temp_tenths   = req_ch.temp_tenths;
      s1_item_in.running       = req_ch.running;
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = stage_fire || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_data_in  = result;

   // ---------------------------------------------------------------------
   // sample classification and fault state update
   // ---------------------------------------------------------------------
   mfcl_detect u_detect (
      .item (s1_item_ff),
      .cfg  (cfg_ff),
      .det  (det)
   );

   mfcl_latch u_latch (
      .clock  (clock),
      .reset  (reset),
      .fire   (stage_fire),
      .item   (s1_item_ff),
      .det    (det),
      .cfg    (cfg_ff),
      .result (result)
   );

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= s1_item_in;
      end
      if (stage_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // result outputs
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.fault_code      = rsp_data_ff.fault_code;
   assign rsp_ch.emergency_stop  = rsp_data_ff.emergency_stop;
   assign rsp_ch.recover_allowed = rsp_data_ff.recover_allowed;
   assign rsp_ch.latch_count     = rsp_data_ff.latch_count;
   assign rsp_ch.retry_total     = rsp_data_ff.retry_total;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // a clear transaction always reports no fault, no stop and no recovery
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      stage_fire && (s1_item_ff.operation == OP_CLEAR) |=>
         (rsp_data_ff.fault_code == FAULT_NONE) && !rsp_data_ff.emergency_stop &&
         !rsp_data_ff.recover_allowed)
      else $error("clear transaction reported a fault");

   // a latch event shows a fault and bumps the fault total by one
   a_estop_counts: assert property (@(posedge clock) disable iff (reset)
      stage_fire && result.emergency_stop |->
         (result.fault_code != FAULT_NONE) &&
         (result.latch_count == u_latch.faults_seen_ff + 32'd1))
      else $error("emergency stop without a latched fault");

   // recovery is only offered while a fault is latched
   a_recover_needs_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.recover_allowed |->
         rsp_data_ff.fault_code != FAULT_NONE)
      else $error("recovery allowed with no fault latched");

   // a held input transaction is neither lost nor overwritten
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register lost a pending transaction");

endmodule

>>> verif/mfcl_tb_pkg.sv
// scoreboard for the motor fault confirm latch: fault state tracking and response checks
package mfcl_tb_pkg;
   import mfcl_pkg::*;

   class fault_tracker;
      cfg_type     cfg;
      fault_type   latched;
      fault_type   pending;
      logic [31:0] latch_stamp;
      logic [31:0] pending_stamp;
      logic [31:0] fault_count;
      logic [7:0]  clear_count;
      result_type  expected_status[$];
      int          errors;

      function new();
         cfg           = CFG_RESET;
         latched       = FAULT_NONE;
         pending       = FAULT_NONE;
         latch_stamp   = '0;
         pending_stamp = '0;
         fault_count   = '0;
         clear_count   = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_CURRENT_LIMIT: cfg.current_limit_ma    = data[14:0];
            REG_TEMP_LIMIT:    cfg.temp_limit_tenths   = data[15:0];
            REG_BUS_MIN:       cfg.bus_min_mv          = data[15:0];
            REG_OC_HOLD:       cfg.overcurrent_hold_ms = data;
            REG_OT_HOLD:       cfg.overtemp_hold_ms    = data;
            REG_STALL_HOLD:    cfg.stall_hold_ms       = data;
            REG_RECOVER_WAIT:  cfg.recover_wait_ms     = data;
            REG_RETRY_LIMIT:   cfg.retry_limit         = data[7:0];
            default: ;
         endcase
      endfunction

      function void latch_fault(fault_type code, logic [31:0] now);
         latched     = code;
         latch_stamp = now;
         pending     = FAULT_NONE;
         fault_count = fault_count + 32'd1;
      endfunction

      // work out the status that one accepted transaction produces
      function void note_sample(item_type it);
         fault_type   cand;
         logic [31:0] hold;
         logic [31:0] held;
         logic [31:0] cooled;
         int          cur_i, temp_i, duty_i, rpm_i;
         logic        stop;
         result_type  r;
         stop   = 1'b0;
         cur_i  = int'(it.motor_current);
         temp_i = int'(it.temp_tenths);
         duty_i = int'(it.duty);
         rpm_i  = int'(it.speed_rpm);
         if (rpm_i < 0) rpm_i = -rpm_i;
         if (it.operation == OP_CLEAR) begin
            latched     = FAULT_NONE;
            latch_stamp = '0;
            if (clear_count != RETRY_MAX) clear_count = clear_count + 8'd1;
         end else if (latched == FAULT_NONE) begin
            cand = FAULT_NONE;
            hold = '0;
            // later tests win, stall is strongest
            if (cur_i > int'(cfg.current_limit_ma)) begin
               cand = FAULT_OVERCURRENT;
               hold = cfg.overcurrent_hold_ms;
            end
            if (temp_i > int'(cfg.temp_limit_tenths)) begin
               cand = FAULT_OVERTEMP;
               hold = cfg.overtemp_hold_ms;
            end
            if (it.running && it.bus_mv < cfg.bus_min_mv) begin
               cand = FAULT_UNDERVOLT;
               hold = '0;
            end
            if (it.running && duty_i > 0 && rpm_i < int'(STALL_RPM)) begin
               cand = FAULT_STALL;
               hold = cfg.stall_hold_ms;
            end
            if (cand == FAULT_NONE) begin
               pending = FAULT_NONE;
            end else if (hold == 32'd0) begin
               latch_fault(cand, it.now_ms);
               stop = 1'b1;
            end else begin
               if (pending != cand) begin
                  pending       = cand;
                  pending_stamp = it.now_ms;
               end
               held = it.now_ms - pending_stamp;
               if (held >= hold) begin
                  latch_fault(cand, it.now_ms);
                  stop = 1'b1;
               end
            end
         end
         cooled            = it.now_ms - latch_stamp;
         r.fault_code      = latched;
         r.emergency_stop  = stop;
         r.recover_allowed = (latched != FAULT_NONE) && (cooled >= cfg.recover_wait_ms)
                             && (clear_count < cfg.retry_limit);
         r.latch_count     = fault_count;
         r.retry_total     = clear_count;
         expected_status.push_back(r);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_status.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.fault_code !== want.fault_code) begin
            $error("fault_code expected %0d got %0d", want.fault_code, got.fault_code);
            errors++;
         end
         if (got.emergency_stop !== want.emergency_stop) begin
            $error("emergency_stop expected %0d got %0d", want.emergency_stop,
                   got.emergency_stop);
            errors++;
         end
         if (got.recover_allowed !== want.recover_allowed) begin
            $error("recover_allowed expected %0d got %0d", want.recover_allowed,
                   got.recover_allowed);
            errors++;
         end
         if (got.latch_count !== want.latch_count) begin
            $error("latch_count expected %0d got %0d", want.latch_count, got.latch_count);
            errors++;
         end
         if (got.retry_total !== want.retry_total) begin
            $error("retry_total expected %0d got %0d", want.retry_total, got.retry_total);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_status.size();
      endfunction

      function void close_out();
         if (expected_status.size() != 0) begin
            $error("%0d responses never arrived", expected_status.size());
            errors++;
         end
      endfunction
   endclass

endpackage

>>> verif/tb.sv
// testbench top for the motor fault confirm latch core
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mfcl_pkg::*;
   import mfcl_tb_pkg::*;

   // bit positions of the candidates a shaped sample asks for
   localparam int WANT_OC    = 0;
   localparam int WANT_OT    = 1;
   localparam int WANT_UV    = 2;
   localparam int WANT_STALL = 3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mfcl_req_if sample_ch();
   mfcl_rsp_if status_ch();

   fault_tracker tracker;
   logic [31:0]  stamp_ms;
   bit           steady = 1'b0;   // no idling on either side while set

   motor_fault_confirm_latch_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (sample_ch),
      .rsp_ch    (status_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic item_type make_item(logic op, logic [31:0] now, int duty, int rpm,
                                          int cur, int bus, int temp, logic run);
      item_type it;
      it.operation     = op;
      it.now_ms        = now;
      it.duty          = duty[15:0];
      it.speed_rpm     = rpm[15:0];
      it.motor_current = cur[15:0];
      it.bus_mv        = bus[15:0];
      it.temp_tenths   = temp[15:0];
      it.running       = run;
      return it;
   endfunction

   // every field random, used for noise and as the body of clear transactions
   function automatic item_type noise_item();
      item_type it;
      it.operation     = 1'($urandom_range(0, 1));
      it.now_ms        = $urandom;
      it.duty          = 16'($urandom);
      it.speed_rpm     = 16'($urandom);
      it.motor_current = 16'($urandom);
      it.bus_mv        = 16'($urandom);
      it.temp_tenths   = 16'($urandom);
      it.running       = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // check sample built against the current limits so the wanted tests fire
   // and the others stay quiet (a wanted test that the limits rule out stays quiet)
   function automatic item_type shaped_sample(logic [3:0] want, logic [31:0] now);
      item_type it;
      int lim, hi, v;
      it           = noise_item();
      it.operation = OP_CHECK;
      it.now_ms    = now;
      // overcurrent
      lim = int'(tracker.cfg.current_limit_ma);
      if (want[WANT_OC] && lim < 32767) begin
         hi = (lim + 40 > 32767) ? 32767 : lim + 40;
         v  = $urandom_range(lim + 1, hi);
      end else begin
         v = int'($urandom_range(0, lim + 32768)) - 32768;
      end
      it.motor_current = v[15:0];
      // overtemperature
      lim = int'(tracker.cfg.temp_limit_tenths);
      if (want[WANT_OT] && lim < 32767) begin
         hi = (lim + 40 > 32767) ? 32767 : lim + 40;
         v  = lim + 1 + int'($urandom_range(0, hi - lim - 1));
      end else begin
         v = int'($urandom_range(0, lim + 32768)) - 32768;
      end
      it.temp_tenths = v[15:0];
      // undervoltage
      lim = int'(tracker.cfg.bus_min_mv);
      if (want[WANT_UV] && lim > 0) v = $urandom_range(0, lim - 1);
      else v = $urandom_range(lim, 65535);
      it.bus_mv = v[15:0];
      if (want[WANT_UV] || want[WANT_STALL]) it.running = 1'b1;
      // stall: positive duty and slow shaft
      if (want[WANT_STALL]) begin
         v = $urandom_range(1, 32767);
         it.duty = v[15:0];
         v = int'($urandom_range(0, 58)) - 29;
         it.speed_rpm = v[15:0];
      end else if ($urandom_range(0, 1)) begin
         v = int'($urandom_range(0, 32768)) - 32768;
         it.duty = v[15:0];
      end else begin
         v = $urandom_range(30, 32768);
         if ($urandom_range(0, 1)) v = -v;
         if (v == 32768) v = -32768;
         it.speed_rpm = v[15:0];
      end
      return it;
   endfunction

   // offer one transaction and wait for its acceptance; valid stays up afterwards
   task automatic send_item(input item_type it);
      int gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         sample_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sample_ch.valid         <= 1'b1;
      sample_ch.operation     <= it.operation;
      sample_ch.now_ms        <= it.now_ms;
      sample_ch.duty          <= it.duty;
      sample_ch.speed_rpm     <= it.speed_rpm;
      sample_ch.motor_current <= it.motor_current;
      sample_ch.bus_mv        <= it.bus_mv;
      sample_ch.temp_tenths   <= it.temp_tenths;
      sample_ch.running       <= it.running;
      @(posedge clock);
      while (!sample_ch.ready) @(posedge clock);
      tracker.note_sample(it);
   endtask

   // sender goes quiet until every outstanding response is back
   task automatic drain();
      int waited;
      waited = 0;
      sample_ch.valid <= 1'b0;
      while (tracker.outstanding() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      put_reg(REG_CURRENT_LIMIT, {17'd0, c.current_limit_ma});
      put_reg(REG_TEMP_LIMIT, {{16{c.temp_limit_tenths[15]}}, c.temp_limit_tenths});
      put_reg(REG_BUS_MIN, {16'd0, c.bus_min_mv});
      put_reg(REG_OC_HOLD, c.overcurrent_hold_ms);
      put_reg(REG_OT_HOLD, c.overtemp_hold_ms);
      put_reg(REG_STALL_HOLD, c.stall_hold_ms);
      put_reg(REG_RECOVER_WAIT, c.recover_wait_ms);
      put_reg(REG_RETRY_LIMIT, {24'd0, c.retry_limit});
      csr_we <= 1'b0;
   endtask

   // runs of samples that keep one candidate mix so confirmation timers can
   // expire, with clears and pure noise mixed in
   task automatic run_random(input int count, input int max_step, input int clear_pct);
      int         run_left, r;
      logic [3:0] want;
      item_type   it;
      run_left = 0;
      want     = '0;
      repeat (count) begin
         if (run_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 25) want = '0;
            else if (r < 70) want = 4'b0001 << $urandom_range(0, 3);
            else want = 4'($urandom_range(0, 15));
            run_left = $urandom_range(1, 12);
         end
         run_left--;
         // timestamps mostly creep forward, sometimes jump at random or step back by one
         r = $urandom_range(0, 99);
         if (r < 88) stamp_ms = stamp_ms + $urandom_range(0, max_step);
         else if (r < 94) stamp_ms = $urandom;
         else stamp_ms = stamp_ms - 32'd1;
         r = $urandom_range(0, 99);
         if (r < clear_pct) begin
            it           = noise_item();
            it.operation = OP_CLEAR;
            it.now_ms    = stamp_ms;
         end else if (r < clear_pct + 10) begin
            it = noise_item();
         end else begin
            it = shaped_sample(want, stamp_ms);
         end
         send_item(it);
      end
   endtask

   // response side: checks every transaction and stalls at random,
   // once for a long stretch so the core backs up into its input
   initial begin : rsp_side
      result_type got;
      int         hold_left;
      int         taken;
      bit         long_done;
      hold_left = 0;
      taken     = 0;
      long_done = 1'b0;
      status_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (status_ch.valid && status_ch.ready) begin
            got.fault_code      = fault_type'(status_ch.fault_code);
            got.emergency_stop  = status_ch.emergency_stop;
            got.recover_allowed = status_ch.recover_allowed;
            got.latch_count     = status_ch.latch_count;
            got.retry_total     = status_ch.retry_total;
            tracker.check_response(got);
            taken++;
         end
         if (!long_done && taken >= 150) begin
            hold_left = 80;
            long_done = 1'b1;
         end else if (hold_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
            hold_left = idle_len();
         end
         status_ch.ready <= (hold_left == 0);
         if (hold_left > 0) hold_left--;
      end
   end

   initial begin : stimulus
      tracker = new();
      reset                   <= 1'b1;
      csr_we                  <= 1'b0;
      csr_index               <= '0;
      csr_wdata               <= '0;
      sample_ch.valid         <= 1'b0;
      sample_ch.operation     <= OP_CHECK;
      sample_ch.now_ms        <= '0;
      sample_ch.duty          <= '0;
      sample_ch.speed_rpm     <= '0;
      sample_ch.motor_current <= '0;
      sample_ch.bus_mv        <= '0;
      sample_ch.temp_tenths   <= '0;
      sample_ch.running       <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset limits
      // low bus while stopped is not undervoltage
      send_item(make_item(OP_CHECK, 32'd0, 0, 0, 0, 0, 0, 1'b0));
      // overcurrent has to persist for its hold time
      send_item(make_item(OP_CHECK, 32'd10, 0, 1000, 32767, 12000, 0, 1'b0));
      send_item(make_item(OP_CHECK, 32'd109, 0, 1000, 8001, 12000, 0, 1'b0));
      send_item(make_item(OP_CHECK, 32'd110, 0, 1000, 8001, 12000, 0, 1'b0));
      // checks are ignored while latched, recovery opens after the cool-down
      send_item(make_item(OP_CHECK, 32'd120, 100, 0, 0, 12000, 0, 1'b1));
      send_item(make_item(OP_CHECK, 32'd5110, 0, 1000, 0, 12000, 0, 1'b0));
      // clear ignores its sample fields, a second clear has nothing latched
      send_item(make_item(OP_CLEAR, 32'd5111, -32768, 32767, -32768, 65535, 32767, 1'b1));
      send_item(make_item(OP_CLEAR, 32'd5112, 0, 0, 0, 0, 0, 1'b0));
      // overtemperature then stall: candidate changes and the timer restarts
      send_item(make_item(OP_CHECK, 32'd6000, 0, 1000, 0, 12000, 32767, 1'b0));
      send_item(make_item(OP_CHECK, 32'd6500, 1, -29, 0, 10000, 801, 1'b1));
      // nothing wrong cancels the timer; full negative speed is not a stall
      send_item(make_item(OP_CHECK, 32'd7000, 32767, -32768, -32768, 65535, -32768, 1'b1));
      send_item(make_item(OP_CHECK, 32'd7001, 32767, 29, 0, 10000, 0, 1'b1));
      send_item(make_item(OP_CHECK, 32'd9001, 32767, 29, 0, 10000, 0, 1'b1));
      send_item(make_item(OP_CLEAR, 32'd9002, 0, 0, 0, 0, 0, 1'b0));
      // undervoltage latches at once; recovery refused once retries reach the limit
      send_item(make_item(OP_CHECK, 32'hFFFF_FF00, 0, 0, 0, 9999, 0, 1'b1));
      send_item(make_item(OP_CHECK, 32'h0000_1288, 0, 0, 0, 12000, 0, 1'b0));
      send_item(make_item(OP_CLEAR, 32'h0000_1289, 0, 0, 0, 0, 0, 1'b0));
      // confirmation across the timestamp wrap
      send_item(make_item(OP_CHECK, 32'hFFFF_FFF0, 0, 1000, 32767, 12000, 0, 1'b0));
      send_item(make_item(OP_CHECK, 32'h0000_0054, 0, 1000, 32767, 12000, 0, 1'b0));
      send_item(make_item(OP_CLEAR, 32'h0000_0055, 0, 0, 0, 0, 0, 1'b0));
      // overtemperature outranks overcurrent
      send_item(make_item(OP_CHECK, 32'd100, 0, 1000, 32767, 12000, 32767, 1'b0));
      send_item(make_item(OP_CHECK, 32'd1100, 0, 1000, 32767, 12000, 32767, 1'b0));
      send_item(make_item(OP_CLEAR, 32'd1101, 0, 0, 0, 0, 0, 1'b0));
      stamp_ms = 32'd1200;

      run_random(70, 300, 10);
      drain();

      // short holds and a quick cool-down; a pending candidate may see its hold change
      apply_settings(cfg_type'{15'd100, 16'sd200, 16'd5000, 32'd5, 32'd7, 32'd3,
                               32'd10, 8'd3});
      run_random(70, 4, 10);
      drain();

      // tightest limits, zero holds and zero retries, back to back on both sides
      apply_settings(cfg_type'{15'd0, 16'sh8000, 16'd65535, 32'd0, 32'd0, 32'd0,
                               32'd0, 8'd0});
      steady = 1'b1;
      run_random(70, 50, 10);
      drain();
      steady = 1'b0;

      // loosest limits and longest holds
      apply_settings(cfg_type'{15'h7FFF, 16'sh7FFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255});
      // a stall held for the full counter span still confirms
      stamp_ms = 32'd5;
      send_item(make_item(OP_CLEAR, stamp_ms, 0, 0, 0, 0, 0, 1'b0));
      send_item(shaped_sample(4'b0000, stamp_ms));
      stamp_ms = 32'd7;
      send_item(shaped_sample(4'b1000, stamp_ms));
      stamp_ms = 32'd6;
      send_item(shaped_sample(4'b1000, stamp_ms));
      run_random(70, 1000, 10);
      drain();

      // mostly clears so the retry count saturates
      apply_settings(cfg_type'{15'd1000, 16'sd0, 16'd12000, 32'd0, 32'd1, 32'd2,
                               32'd0, 8'd255});
      run_random(300, 3, 80);
      drain();

      tracker.close_out();
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
